// ----- rtl/dfiir_pkg.sv -----
// Shared types, widths and codes for the direct-form IIR filter.
package dfiir_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int TAP_W       = 4;
    localparam int CNT_W       = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W       = 56;
    localparam int HALF_W      = ACC_W / 2;
    localparam int NOP_W       = HALF_W + 1;
    localparam int NPROD_W     = NOP_W + SAMPLE_BITS;
    localparam int NUM_W       = 82;
    localparam int DEN_W       = 2 * SAMPLE_BITS;
    localparam int DIV_STEPS   = SAMPLE_BITS;
    localparam int DSTEP_W     = 5;
    localparam int NSTEP_W     = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam logic [1:0] ACT_WRITE_B = 2'd0;
    localparam logic [1:0] ACT_WRITE_A = 2'd1;
    localparam logic [1:0] ACT_FILTER  = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SAT     = 2'd1;
    localparam logic [1:0] ST_A0_ZERO = 2'd2;

    localparam logic [1:0] CFG_NB = 2'd0;
    localparam logic [1:0] CFG_NA = 2'd1;
    localparam logic [1:0] CFG_CM = 2'd2;

    // numerator steps: squared magnitude first, then the four partial products
    localparam logic [NSTEP_W-1:0] NSTEP_DEN      = 3'd0;
    localparam logic [NSTEP_W-1:0] NSTEP_ACC_LO   = 3'd1;
    localparam logic [NSTEP_W-1:0] NSTEP_ACC_HI   = 3'd2;
    localparam logic [NSTEP_W-1:0] NSTEP_CROSS_LO = 3'd3;
    localparam logic [NSTEP_W-1:0] NSTEP_CROSS_HI = 3'd4;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic round;
    } div_cmd_t;

    typedef struct packed {
        logic               accept;
        logic               cplx;
        logic               mac_valid;
        logic               mac_fb;
        logic [TAP_W-1:0]   mac_idx;
        logic               num_valid;
        logic [NSTEP_W-1:0] num_step;
        div_cmd_t           div;
        logic               out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/dfiir_div.sv -----
// Restoring divider lane: rounded, saturated quotient of numerator by squared magnitude.
module dfiir_div (
    input  logic                                     clk,
    input  dfiir_pkg::div_cmd_t                      cmd,
    input  logic signed [dfiir_pkg::NUM_W-1:0]       num,
    input  logic [dfiir_pkg::DEN_W-1:0]              den,
    output dfiir_pkg::sample_t                       y,
    output logic                                     sat
);

    localparam int NW = dfiir_pkg::NUM_W;
    localparam int SB = dfiir_pkg::SAMPLE_BITS;
    localparam int DW = dfiir_pkg::DEN_W;

    logic              neg_reg;
    logic [NW-1:0]     mag_reg;
    logic              pre_sat_reg;
    logic [DW-1:0]     rem_reg;
    logic [SB-1:0]     low_reg;
    logic [SB-1:0]     q_reg;
    dfiir_pkg::sample_t y_reg;
    logic              sat_reg;

    logic [DW:0]       r2;
    logic              fits;
    logic              rnd;
    logic [SB:0]       q25;
    logic [SB:0]       lim;
    logic              sat_final;
    logic [SB:0]       mag_out;

    always_comb
    begin
        r2        = {rem_reg, low_reg[SB-1]};
        fits      = r2 >= {1'b0, den};
        rnd       = {rem_reg, 1'b0} >= {1'b0, den};
        q25       = {1'b0, q_reg} + (SB+1)'(rnd);
        lim       = ((SB+1)'(1) << (SB-1)) - (SB+1)'(!neg_reg);
        sat_final = pre_sat_reg || (q25 > lim);
        mag_out   = sat_final ? lim : q25;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= num[NW-1];
            mag_reg <= num[NW-1] ? NW'(-num) : NW'(num);
        end
        if (cmd.init)
        begin
            // quotient of 2^SB or more always clamps
            pre_sat_reg <= mag_reg[NW-1:SB] >= (NW-SB)'(den);
            rem_reg     <= mag_reg[SB+DW-1:SB];
            low_reg     <= mag_reg[SB-1:0];
            q_reg       <= '0;
        end
        if (cmd.step)
        begin
            rem_reg <= fits ? DW'(r2 - {1'b0, den}) : r2[DW-1:0];
            q_reg   <= {q_reg[SB-2:0], fits};
            low_reg <= {low_reg[SB-2:0], 1'b0};
        end
        if (cmd.round)
        begin
            y_reg   <= neg_reg ? -$signed(mag_out[SB-1:0]) : $signed(mag_out[SB-1:0]);
            sat_reg <= sat_final;
        end
    end

    assign y   = y_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/dfiir_datapath.sv -----
// Datapath: coefficient and history registers, complex MAC, numerator and divider lanes.
module dfiir_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dfiir_pkg::cmd_t                     cmd,
    input  logic [1:0]                          action,
    input  logic [dfiir_pkg::TAP_W-1:0]         tap_index,
    input  dfiir_pkg::sample_t                  value_re,
    input  dfiir_pkg::sample_t                  value_im,
    input  logic                                out_stall,
    output dfiir_pkg::stat_t                    stat,
    output logic                                out_valid,
    output dfiir_pkg::sample_t                  out_re,
    output dfiir_pkg::sample_t                  out_im,
    output logic [1:0]                          status
);

    localparam int NT = dfiir_pkg::MAX_TAPS;
    localparam int PW = dfiir_pkg::PROD_W;
    localparam int AW = dfiir_pkg::ACC_W;
    localparam int HW = dfiir_pkg::HALF_W;
    localparam int OW = dfiir_pkg::NOP_W;
    localparam int MW = dfiir_pkg::NPROD_W;
    localparam int NW = dfiir_pkg::NUM_W;
    localparam int DW = dfiir_pkg::DEN_W;

    dfiir_pkg::sample_t b_re_reg [NT];
    dfiir_pkg::sample_t b_im_reg [NT];
    dfiir_pkg::sample_t a_re_reg [NT];
    dfiir_pkg::sample_t a_im_reg [NT];
    dfiir_pkg::sample_t xh_re_reg [NT];
    dfiir_pkg::sample_t xh_im_reg [NT];
    dfiir_pkg::sample_t yh_re_reg [NT];
    dfiir_pkg::sample_t yh_im_reg [NT];

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                 pv_reg;
    logic                 pfb_reg;
    logic signed [AW-1:0] acc_re_reg, acc_im_reg;

    logic signed [MW-1:0] np_re_reg, np_im_reg;
    logic                 nv_reg;
    logic [dfiir_pkg::NSTEP_W-1:0] nstep_reg;
    logic signed [NW-1:0] num_re_reg, num_im_reg;
    logic [DW-1:0]        den_reg;

    logic                 out_valid_reg;
    dfiir_pkg::sample_t   out_re_reg, out_im_reg;
    logic [1:0]           status_reg;

    logic                 start;
    logic [dfiir_pkg::TAP_W-1:0] prev_idx;
    dfiir_pkg::sample_t   cr, ci, dr, di;
    logic signed [PW:0]   t_re, t_im;
    logic signed [AW-1:0] add_re, add_im;

    dfiir_pkg::sample_t   cre, cim;
    logic signed [OW-1:0] are_lo, are_hi, aim_lo, aim_hi;
    logic signed [OW-1:0] op_a_re, op_a_im;
    dfiir_pkg::sample_t   op_b_re, op_b_im;
    logic signed [MW-1:0] den_sum;
    logic                 hi_step, sub_step;
    logic signed [NW-1:0] sh_re, sh_im;

    dfiir_pkg::sample_t   y_re, y_im;
    logic                 sat_re, sat_im;
    logic                 den_zero;
    dfiir_pkg::sample_t   fin_re, fin_im;
    logic [1:0]           fin_status;

    assign start    = cmd.accept && (action == dfiir_pkg::ACT_FILTER);
    assign prev_idx = cmd.mac_idx - 1'b1;

    // coefficient tap and history operand for the tap being walked
    always_comb
    begin
        if (cmd.mac_fb)
        begin
            cr = a_re_reg[cmd.mac_idx];
            ci = cmd.cplx ? a_im_reg[cmd.mac_idx] : '0;
            dr = yh_re_reg[prev_idx];
            di = cmd.cplx ? yh_im_reg[prev_idx] : '0;
        end
        else
        begin
            cr = b_re_reg[cmd.mac_idx];
            ci = cmd.cplx ? b_im_reg[cmd.mac_idx] : '0;
            dr = xh_re_reg[cmd.mac_idx];
            di = cmd.cplx ? xh_im_reg[cmd.mac_idx] : '0;
        end
        t_re   = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
        t_im   = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
        add_re = pfb_reg ? -AW'(t_re) : AW'(t_re);
        add_im = pfb_reg ? -AW'(t_im) : AW'(t_im);
    end

    // numerator partial products: accumulator split in two halves
    always_comb
    begin
        cre    = a_re_reg[0];
        cim    = cmd.cplx ? a_im_reg[0] : '0;
        are_lo = $signed({1'b0, acc_re_reg[HW-1:0]});
        are_hi = OW'($signed(acc_re_reg[AW-1:HW]));
        aim_lo = $signed({1'b0, acc_im_reg[HW-1:0]});
        aim_hi = OW'($signed(acc_im_reg[AW-1:HW]));
        case (cmd.num_step)
            dfiir_pkg::NSTEP_DEN:
            begin
                op_a_re = OW'(cre);  op_b_re = cre;
                op_a_im = OW'(cim);  op_b_im = cim;
            end
            dfiir_pkg::NSTEP_ACC_LO:
            begin
                op_a_re = are_lo;    op_b_re = cre;
                op_a_im = aim_lo;    op_b_im = cre;
            end
            dfiir_pkg::NSTEP_ACC_HI:
            begin
                op_a_re = are_hi;    op_b_re = cre;
                op_a_im = aim_hi;    op_b_im = cre;
            end
            dfiir_pkg::NSTEP_CROSS_LO:
            begin
                op_a_re = aim_lo;    op_b_re = cim;
                op_a_im = are_lo;    op_b_im = cim;
            end
            dfiir_pkg::NSTEP_CROSS_HI:
            begin
                op_a_re = aim_hi;    op_b_re = cim;
                op_a_im = are_hi;    op_b_im = cim;
            end
            default:
            begin
                op_a_re = '0;        op_b_re = '0;
                op_a_im = '0;        op_b_im = '0;
            end
        endcase
        den_sum  = np_re_reg + np_im_reg;
        hi_step  = (nstep_reg == dfiir_pkg::NSTEP_ACC_HI) ||
                   (nstep_reg == dfiir_pkg::NSTEP_CROSS_HI);
        sub_step = (nstep_reg == dfiir_pkg::NSTEP_CROSS_LO) ||
                   (nstep_reg == dfiir_pkg::NSTEP_CROSS_HI);
        sh_re    = hi_step ? (NW'(np_re_reg) <<< HW) : NW'(np_re_reg);
        sh_im    = hi_step ? (NW'(np_im_reg) <<< HW) : NW'(np_im_reg);
    end

    always_comb
    begin
        den_zero = (den_reg == '0);
        fin_re   = den_zero ? '0 : y_re;
        fin_im   = (den_zero || !cmd.cplx) ? '0 : y_im;
        if (den_zero)
            fin_status = dfiir_pkg::ST_A0_ZERO;
        else if (sat_re || sat_im)
            fin_status = dfiir_pkg::ST_SAT;
        else
            fin_status = dfiir_pkg::ST_OK;
    end

    // coefficient and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NT; k++)
            begin
                b_re_reg[k]  <= '0;
                b_im_reg[k]  <= '0;
                a_re_reg[k]  <= '0;
                a_im_reg[k]  <= '0;
                xh_re_reg[k] <= '0;
                xh_im_reg[k] <= '0;
                yh_re_reg[k] <= '0;
                yh_im_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                unique case (action)
                    dfiir_pkg::ACT_WRITE_B:
                    begin
                        b_re_reg[tap_index] <= value_re;
                        b_im_reg[tap_index] <= value_im;
                    end
                    dfiir_pkg::ACT_WRITE_A:
                    begin
                        a_re_reg[tap_index] <= value_re;
                        a_im_reg[tap_index] <= value_im;
                    end
                    dfiir_pkg::ACT_FILTER:
                    begin
                        for (int k = NT - 1; k > 0; k--)
                        begin
                            xh_re_reg[k] <= xh_re_reg[k-1];
                            xh_im_reg[k] <= xh_im_reg[k-1];
                        end
                        xh_re_reg[0] <= value_re;
                        xh_im_reg[0] <= cmd.cplx ? value_im : '0;
                    end
                    dfiir_pkg::ACT_CLEAR:
                    begin
                        for (int k = 0; k < NT; k++)
                        begin
                            xh_re_reg[k] <= '0;
                            xh_im_reg[k] <= '0;
                            yh_re_reg[k] <= '0;
                            yh_im_reg[k] <= '0;
                        end
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                for (int k = NT - 1; k > 0; k--)
                begin
                    yh_re_reg[k] <= yh_re_reg[k-1];
                    yh_im_reg[k] <= yh_im_reg[k-1];
                end
                yh_re_reg[0] <= fin_re;
                yh_im_reg[0] <= fin_im;
            end
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= 1'b0;
            nv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.mac_valid;
            nv_reg <= cmd.num_valid;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_valid)
        begin
            p_rr_reg <= cr * dr;
            p_ii_reg <= ci * di;
            p_ri_reg <= cr * di;
            p_ir_reg <= ci * dr;
            pfb_reg  <= cmd.mac_fb;
        end
        if (start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_re_reg <= acc_re_reg + add_re;
            acc_im_reg <= acc_im_reg + add_im;
        end

        if (cmd.num_valid)
        begin
            np_re_reg <= op_a_re * op_b_re;
            np_im_reg <= op_a_im * op_b_im;
            nstep_reg <= cmd.num_step;
        end
        if (start)
        begin
            num_re_reg <= '0;
            num_im_reg <= '0;
        end
        else if (nv_reg)
        begin
            if (nstep_reg == dfiir_pkg::NSTEP_DEN)
                den_reg <= den_sum[DW-1:0];
            else
            begin
                num_re_reg <= num_re_reg + sh_re;
                num_im_reg <= sub_step ? num_im_reg - sh_im : num_im_reg + sh_im;
            end
        end

        if (cmd.out_load)
        begin
            out_re_reg <= fin_re;
            out_im_reg <= fin_im;
            status_reg <= fin_status;
        end
    end

    dfiir_div u_div_re (
        .clk (clk),
        .cmd (cmd.div),
        .num (num_re_reg),
        .den (den_reg),
        .y   (y_re),
        .sat (sat_re)
    );

    dfiir_div u_div_im (
        .clk (clk),
        .cmd (cmd.div),
        .num (num_im_reg),
        .den (den_reg),
        .y   (y_im),
        .sat (sat_im)
    );

    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign out_re        = out_re_reg;
    assign out_im        = out_im_reg;
    assign status        = status_reg;

endmodule

// ----- rtl/dfiir_ctrl.sv -----
// Controller: configuration registers and the sequencer for the tap walk and divide.
module dfiir_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           action,
    output logic                 in_stall,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    output logic                 cfg_ready,
    input  dfiir_pkg::stat_t     stat,
    output dfiir_pkg::cmd_t      cmd
);

    localparam int CW = dfiir_pkg::CNT_W;
    localparam int TW = dfiir_pkg::TAP_W;
    localparam int DSW = dfiir_pkg::DSTEP_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FF     = 4'd1;
    localparam logic [3:0] S_FB     = 4'd2;
    localparam logic [3:0] S_MFLUSH = 4'd3;
    localparam logic [3:0] S_NUM    = 4'd4;
    localparam logic [3:0] S_NFLUSH = 4'd5;
    localparam logic [3:0] S_DLOAD  = 4'd6;
    localparam logic [3:0] S_DINIT  = 4'd7;
    localparam logic [3:0] S_DSTEP  = 4'd8;
    localparam logic [3:0] S_DROUND = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0]   state_reg, state_next;
    logic [TW-1:0] j_reg, j_next;
    logic [dfiir_pkg::NSTEP_W-1:0] n_reg, n_next;
    logic [DSW-1:0] d_reg, d_next;
    logic [CW-1:0] nb_reg, na_reg;
    logic          cm_reg;
    logic [CW-1:0] nb_eff, na_eff;
    logic          accept;

    always_comb
    begin
        nb_eff = (nb_reg > CW'(dfiir_pkg::MAX_TAPS)) ? CW'(dfiir_pkg::MAX_TAPS) : nb_reg;
        if (na_reg > CW'(dfiir_pkg::MAX_TAPS))
            na_eff = CW'(dfiir_pkg::MAX_TAPS);
        else if (na_reg == '0)
            na_eff = CW'(1);
        else
            na_eff = na_reg;
    end

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.cplx      = cm_reg;
        cmd.mac_idx   = j_reg;
        cmd.num_step  = n_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == dfiir_pkg::ACT_FILTER))
                begin
                    if (nb_eff != '0)
                    begin
                        state_next = S_FF;
                        j_next     = '0;
                    end
                    else if (na_eff > CW'(1))
                    begin
                        state_next = S_FB;
                        j_next     = TW'(1);
                    end
                    else
                        state_next = S_MFLUSH;
                end
            end
            S_FF:
            begin
                cmd.mac_valid = 1'b1;
                if ({1'b0, j_reg} == nb_eff - 1'b1)
                begin
                    if (na_eff > CW'(1))
                    begin
                        state_next = S_FB;
                        j_next     = TW'(1);
                    end
                    else
                        state_next = S_MFLUSH;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            S_FB:
            begin
                cmd.mac_valid = 1'b1;
                cmd.mac_fb    = 1'b1;
                if ({1'b0, j_reg} == na_eff - 1'b1)
                    state_next = S_MFLUSH;
                else
                    j_next = j_reg + 1'b1;
            end
            S_MFLUSH:
            begin
                state_next = S_NUM;
                n_next     = dfiir_pkg::NSTEP_DEN;
            end
            S_NUM:
            begin
                cmd.num_valid = 1'b1;
                if (n_reg == dfiir_pkg::NSTEP_CROSS_HI)
                    state_next = S_NFLUSH;
                else
                    n_next = n_reg + 1'b1;
            end
            S_NFLUSH:
                state_next = S_DLOAD;
            S_DLOAD:
            begin
                cmd.div.load = 1'b1;
                state_next   = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div.init = 1'b1;
                d_next       = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div.step = 1'b1;
                if (d_reg == DSW'(dfiir_pkg::DIV_STEPS - 1))
                    state_next = S_DROUND;
                else
                    d_next = d_reg + 1'b1;
            end
            S_DROUND:
            begin
                cmd.div.round = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            n_reg     <= '0;
            d_reg     <= '0;
            nb_reg    <= CW'(1);
            na_reg    <= CW'(1);
            cm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            d_reg     <= d_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    dfiir_pkg::CFG_NB: nb_reg <= cfg_data;
                    dfiir_pkg::CFG_NA: na_reg <= cfg_data;
                    dfiir_pkg::CFG_CM: cm_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/direct_form_iir_filter.sv -----
// Top level of the direct-form I IIR filter, real or complex, in fixed point.
//
// Input channel (in_valid/in_stall) carries one transaction per action:
// coefficient write b or a, filter sample, or clear history. A transaction is
// taken when in_valid is high and in_stall is low. Writes and clears finish in
// the cycle they are taken. A filter sample walks the taps on one complex
// multiply-accumulate, one tap per cycle, then forms the squared magnitude
// and numerator in five multiply steps and runs a 24-step restoring divide on
// the real and imaginary lanes together.
// The walk covers NB feed-forward and NA - 1 feedback taps (NB, NA the clamped
// tap counts, NA at least one); in_stall stays high until the result is loaded,
// so the next sample is taken only after the last one is through.
// Output channel (out_valid/out_stall) holds each result in a register until
// it is taken; while the receiver stalls, the next sample still computes and
// waits only at the final load.
// Configuration port (cfg_valid/cfg_ready) is always ready; write it only
// when the block is idle.
// Reset clears all coefficients and histories and sets one b tap, one a tap
// and real mode.
module direct_form_iir_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [3:0]           tap_index,
    input  logic signed [23:0]   value_re,
    input  logic signed [23:0]   value_im,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [23:0]   out_re,
    output logic signed [23:0]   out_im,
    output logic [1:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_data
);

    dfiir_pkg::cmd_t  cmd;
    dfiir_pkg::stat_t stat;

    dfiir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dfiir_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .tap_index (tap_index),
        .value_re  (value_re),
        .value_im  (value_im),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_re    (out_re),
        .out_im    (out_im),
        .status    (status)
    );

endmodule

// ----- rtl/dfiir_checker.sv -----
// Port-level checks for the IIR filter, bound to the top level.
module dfiir_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [1:0]           action,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic signed [23:0]   out_re,
    input logic signed [23:0]   out_im,
    input logic [1:0]           status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_re) && $stable(out_im) && $stable(status))
        else $error("stalled result changed");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == dfiir_pkg::ACT_FILTER |=> in_stall)
        else $error("input not stalled while a sample is computed");

    a_zero_a0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dfiir_pkg::ST_A0_ZERO |-> out_re == '0 && out_im == '0)
        else $error("nonzero output with zero leading feedback tap");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

endmodule

bind direct_form_iir_filter dfiir_checker u_dfiir_checker (.*);

// ----- test/tb.sv -----
// Testbench for direct_form_iir_filter: directed table, then random phases, checked by a predictor.
`timescale 1ns / 100ps

module tb;
    import dfiir_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int PHASES = 10;
    localparam int PER_PHASE = 150;
    localparam int DRAIN = 80;                  // outlasts a full sample at the largest tap counts
    localparam longint ONE_Q20 = 64'sd1048576;

    typedef struct packed {
        sample_t    re;
        sample_t    im;
        logic [1:0] st;
    } filt_out_t;

    typedef struct packed {
        logic [1:0] act;
        logic [3:0] idx;
        sample_t    re;
        sample_t    im;
        logic       typed;
        filt_out_t  res;
    } dir_row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic [1:0]     action = ACT_CLEAR;
    logic [3:0]     tap_index = '0;
    sample_t        value_re = '0;
    sample_t        value_im = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    sample_t        out_re;
    sample_t        out_im;
    logic [1:0]     status;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = CFG_NB;
    logic [4:0]     cfg_data = '0;

    direct_form_iir_filter uut (.*);

    // filter state as the block should hold it
    longint ff_re[MAX_TAPS], ff_im[MAX_TAPS], fb_re[MAX_TAPS], fb_im[MAX_TAPS];
    longint xh_re[MAX_TAPS], xh_im[MAX_TAPS], yh_re[MAX_TAPS], yh_im[MAX_TAPS];
    int     nb_cfg = 1, na_cfg = 1;
    bit     cplx_cfg = 0;

    filt_out_t pending_outputs[$];
    int  errors = 0;
    bit  quiet = 0;
    int  n_samples = 0, n_writes = 0, n_clears = 0, n_cfg = 0, n_sat = 0, n_a0zero = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("timeout: %0d results still pending", pending_outputs.size());
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // round to nearest, ties away from zero, then clamp to a sample
    function automatic longint round_div(logic signed [127:0] n, longint d, inout bit sat);
        logic [127:0] mag, q, r, dd, lim;
        bit neg;
        neg = n < 0;
        mag = neg ? -n : n;
        dd = 128'(d);
        q = mag / dd;
        r = mag % dd;
        if (r >= dd - r)
            q = q + 1;
        lim = neg ? 128'd8388608 : 128'd8388607;
        if (q > lim) begin
            sat = 1;
            q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit filter_action(logic [1:0] act, logic [3:0] idx, sample_t vre,
                                         sample_t vim, output filt_out_t res);
        logic signed [127:0] are, aim, nre, nim;
        longint xr, xi, cr, ci, pr, pi, den, yre, yim;
        int nb, na;
        bit sat;
        res = '0;
        case (act)
            ACT_WRITE_B: begin ff_re[idx] = vre; ff_im[idx] = vim; return 0; end
            ACT_WRITE_A: begin fb_re[idx] = vre; fb_im[idx] = vim; return 0; end
            ACT_CLEAR: begin
                foreach (xh_re[k]) begin
                    xh_re[k] = 0; xh_im[k] = 0; yh_re[k] = 0; yh_im[k] = 0;
                end
                return 0;
            end
            default: ;
        endcase
        for (int k = MAX_TAPS - 1; k > 0; k--) begin
            xh_re[k] = xh_re[k-1];
            xh_im[k] = xh_im[k-1];
        end
        xh_re[0] = vre;
        xh_im[0] = cplx_cfg ? longint'(vim) : 0;
        nb = nb_cfg > MAX_TAPS ? MAX_TAPS : nb_cfg;
        na = na_cfg > MAX_TAPS ? MAX_TAPS : na_cfg;
        are = 0;
        aim = 0;
        for (int j = 0; j < nb; j++) begin
            cr = ff_re[j]; ci = cplx_cfg ? ff_im[j] : 0;
            xr = xh_re[j]; xi = cplx_cfg ? xh_im[j] : 0;
            are = are + cr * xr - ci * xi;
            aim = aim + cr * xi + ci * xr;
        end
        for (int j = 1; j < na; j++) begin
            cr = fb_re[j]; ci = cplx_cfg ? fb_im[j] : 0;
            pr = yh_re[j-1]; pi = cplx_cfg ? yh_im[j-1] : 0;
            are = are - cr * pr + ci * pi;
            aim = aim - cr * pi - ci * pr;
        end
        cr = fb_re[0];
        ci = cplx_cfg ? fb_im[0] : 0;
        den = cr * cr + ci * ci;
        yre = 0;
        yim = 0;
        sat = 0;
        if (den == 0) begin
            res.st = ST_A0_ZERO;
        end else begin
            nre = are * cr + aim * ci;
            nim = aim * cr - are * ci;
            yre = round_div(nre, den, sat);
            yim = round_div(nim, den, sat);
            if (!cplx_cfg) yim = 0;
            res.st = sat ? ST_SAT : ST_OK;
        end
        for (int k = MAX_TAPS - 1; k > 0; k--) begin
            yh_re[k] = yh_re[k-1];
            yh_im[k] = yh_im[k-1];
        end
        yh_re[0] = yre;
        yh_im[0] = yim;
        res.re = sample_t'(yre);
        res.im = sample_t'(yim);
        return 1;
    endfunction

    task automatic send_action(logic [1:0] act, logic [3:0] idx, sample_t vre, sample_t vim,
                               bit typed = 0, filt_out_t want = '0);
        filt_out_t res;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        tap_index <= idx;
        value_re  <= vre;
        value_im  <= vim;
        do @(posedge clk); while (in_stall);
        if (filter_action(act, idx, vre, vim, res)) begin
            pending_outputs.push_back(typed ? want : res);
            n_samples++;
            if (res.st == ST_SAT) n_sat++;
            if (res.st == ST_A0_ZERO) n_a0zero++;
        end else if (act == ACT_CLEAR) n_clears++;
        else n_writes++;
    endtask

    // block must be idle: all results in, then a full latency of margin
    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NB: nb_cfg = data;
            CFG_NA: na_cfg = data;
            CFG_CM: cplx_cfg = data[0];
            default: ;
        endcase
        n_cfg++;
    endtask

    function automatic sample_t rand_value();
        case ($urandom_range(0, 9))
            0: return sample_t'($urandom);
            1: case ($urandom_range(0, 3))
                   0: return 24'sh7FFFFF;
                   1: return 24'sh800000;
                   2: return '0;
                   default: return '1;
               endcase
            default: return sample_t'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    // leading feedback tap: mostly near unity, sometimes zero or arbitrary
    function automatic sample_t rand_a0();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return rand_value();
            default: return sample_t'(ONE_Q20 + longint'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic random_action();
        int r;
        logic [3:0] idx;
        r = $urandom_range(0, 99);
        idx = 4'($urandom);
        if (r < 55)
            send_action(ACT_FILTER, idx, rand_value(), rand_value());
        else if (r < 83)
            send_action(ACT_WRITE_B, idx, rand_value(), rand_value());
        else if (r < 96) begin
            if (idx == 0)
                send_action(ACT_WRITE_A, idx, rand_a0(), $urandom_range(0, 1) ? '0 : rand_value());
            else
                send_action(ACT_WRITE_A, idx, sample_t'(rand_value() >>> $urandom_range(0, 4)),
                            rand_value());
        end else
            send_action(ACT_CLEAR, idx, rand_value(), rand_value());
    endtask

    // output side: check every transaction, stall in bursts
    initial begin
        int hold;
        bit stalling;
        filt_out_t want;
        hold = 0;
        stalling = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_outputs.size() == 0)
                    report_mismatch("unexpected result", out_re, 0);
                else begin
                    want = pending_outputs.pop_front();
                    if (out_re !== want.re) report_mismatch("out_re", out_re, want.re);
                    if (out_im !== want.im) report_mismatch("out_im", out_im, want.im);
                    if (status !== want.st) report_mismatch("status", status, want.st);
                end
            end
            if (hold > 0)
                hold--;
            else if (quiet)
                stalling = 0;
            else begin
                stalling = !stalling && $urandom_range(0, 1);
                hold = stalling ? $urandom_range(1, 13) : $urandom_range(1, 40);
            end
            out_stall <= stalling && !quiet;
        end
    end

    dir_row_t dir_rows[] = '{
        '{ACT_FILTER,  4'd0,  24'sd12345,   24'sd77,      1'b1, '{24'sd0, 24'sd0, ST_A0_ZERO}},
        '{ACT_WRITE_A, 4'd0,  24'sh100000,  24'sd0,       1'b0, '0},
        '{ACT_WRITE_B, 4'd0,  24'sh100000,  24'sd0,       1'b0, '0},
        '{ACT_FILTER,  4'd3,  24'sh7FFFFF,  24'sd0,       1'b1, '{24'sh7FFFFF, 24'sd0, ST_OK}},
        '{ACT_FILTER,  4'd0,  24'sh800000,  24'sh7FFFFF,  1'b1, '{24'sh800000, 24'sd0, ST_OK}},
        '{ACT_FILTER,  4'd15, 24'sd0,       -24'sd1,      1'b1, '{24'sd0, 24'sd0, ST_OK}},
        '{ACT_WRITE_B, 4'd0,  24'sh7FFFFF,  24'sh800000,  1'b0, '0},
        '{ACT_FILTER,  4'd0,  24'sh7FFFFF,  24'sd0,       1'b1, '{24'sh7FFFFF, 24'sd0, ST_SAT}},
        '{ACT_FILTER,  4'd0,  24'sh800000,  24'sd0,       1'b1, '{24'sh800000, 24'sd0, ST_SAT}},
        '{ACT_WRITE_B, 4'd0,  24'sh800000,  24'sd5,       1'b0, '0},
        '{ACT_FILTER,  4'd0,  24'sh800000,  24'sd0,       1'b1, '{24'sh7FFFFF, 24'sd0, ST_SAT}},
        '{ACT_WRITE_B, 4'd15, 24'sd123456,  -24'sd99,     1'b0, '0},
        '{ACT_WRITE_A, 4'd15, -24'sd5000,   24'sh7FFFFF,  1'b0, '0},
        '{ACT_CLEAR,   4'd9,  24'sh7FFFFF,  24'sh800000,  1'b0, '0},
        '{ACT_WRITE_A, 4'd0,  24'sh7FFFFF,  24'sd0,       1'b0, '0},
        '{ACT_WRITE_B, 4'd0,  24'sh100000,  24'sd0,       1'b0, '0},
        '{ACT_FILTER,  4'd0,  24'sd4000000, 24'sd0,       1'b0, '0},
        '{ACT_WRITE_A, 4'd0,  24'sh800000,  24'sd0,       1'b0, '0},
        '{ACT_FILTER,  4'd0,  -24'sd3999999, 24'sd0,      1'b0, '0},
        '{ACT_WRITE_A, 4'd1,  24'sh080000,  24'sd0,       1'b0, '0},
        '{ACT_WRITE_B, 4'd1,  24'sh080000,  24'sh555555,  1'b0, '0},
        '{ACT_FILTER,  4'd0,  24'sd1000,    24'shAAAAAA,  1'b0, '0}
    };

    initial begin
        foreach (ff_re[k]) begin
            ff_re[k] = 0; ff_im[k] = 0; fb_re[k] = 0; fb_im[k] = 0;
            xh_re[k] = 0; xh_im[k] = 0; yh_re[k] = 0; yh_im[k] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_action(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].re, dir_rows[i].im,
                        dir_rows[i].typed, dir_rows[i].res);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin write_reg(CFG_NB, 5'd16); write_reg(CFG_NA, 5'd16);
                         write_reg(CFG_CM, 5'd1); end
                1: begin write_reg(CFG_NB, 5'd31); write_reg(CFG_NA, 5'd0);
                         write_reg(CFG_CM, 5'd30); end
                2: begin write_reg(CFG_NB, 5'd0); write_reg(CFG_NA, 5'd1);
                         write_reg(CFG_CM, 5'd3); write_reg(CFG_SPARE, 5'd31); end
                default: begin
                    write_reg(CFG_NB, 5'($urandom)); write_reg(CFG_NA, 5'($urandom));
                    write_reg(CFG_CM, 5'($urandom));
                end
            endcase
            quiet = (p == PHASES - 1);
            for (int i = 0; i < PER_PHASE; i++)
                random_action();
        end
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("ran %0d samples (%0d saturated, %0d with zero a0), %0d tap writes,",
                 n_samples, n_sat, n_a0zero, n_writes);
        $display("%0d history clears and %0d register writes over %0d phases",
                 n_clears, n_cfg, PHASES);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dfiir_pkg.sv
rtl/dfiir_div.sv
rtl/dfiir_datapath.sv
rtl/dfiir_ctrl.sv
rtl/direct_form_iir_filter.sv
rtl/dfiir_checker.sv
test/tb.sv
